// File: design/mcwc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Multiply-carry word checksum package
// Shared widths and constants for the checksum core.
// ----------------------------------------------------------------------------
package mcwc_pkg;

    // Width of one stored digit and of one input word.
    localparam int DIGIT_W = 16;

    // Multiplier applied to each digit as the carry ripples through.
    localparam logic [DIGIT_W:0] MUL_FACTOR = 17'd41719;

    // Default number of stored digits.
    localparam int NUM_DIGITS_DEF = 4;

    // Number of digits shown in the digest, and its width.
    localparam int SHOWN_DIGITS = 4;
    localparam int DIGEST_W     = DIGIT_W * SHOWN_DIGITS;

    // Width of the multiply-accumulate sum.
    localparam int SUM_W = 2 * DIGIT_W;

endpackage : mcwc_pkg
`default_nettype wire

// File: design/multiply_carry_word_checksum_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Multiply-carry word checksum core
// Folds a stream of 16-bit words into a running 64-bit digest, one digit a
// cycle unless the output stalls, through a single multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Each accepted item is folded digit by digit: the carry passes through the
// stored digits one 16-bit digit per cycle, through one 16 x 17 bit
// multiply-accumulate that sits at the head of a rotating digit shift line.
// The first step runs in the cycle the item is accepted, and no new item
// is taken until its last step is done. A finished digest waits in the output
// register while the next item is already being folded; the last step of
// that item holds until the waiting digest has been taken. An item with the
// first flag set starts a new message with all digits cleared.
module multiply_carry_word_checksum_core
    import mcwc_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // Input items.
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [DIGIT_W-1:0]  s_tdata,   // [15:0] word
    input  wire logic                s_tuser,   // [0] first
    // Result items.
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [DIGEST_W-1:0]      m_tdata    // [63:0] digest
);

    localparam int CNT_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_DIGITS - 1);

    // Digit shift line, head at index 0, and the running carry.
    logic [DIGIT_W-1:0] dig_reg  [NUM_DIGITS];
    logic [DIGIT_W-1:0] dig_next [NUM_DIGITS];
    logic [DIGIT_W-1:0] carry_reg, carry_next;

    // Step control.
    logic               busy_reg, busy_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [DIGEST_W-1:0] out_data_reg, out_data_next;

    logic               accept;
    logic               last_step;
    logic               step_en;
    logic               clear;
    logic [DIGIT_W-1:0] head;
    logic [DIGIT_W-1:0] carry_in;
    logic [SUM_W-1:0]   sum;

    assign s_tready  = !busy_reg;
    assign accept    = s_tvalid && s_tready;
    assign clear     = accept && s_tuser;
    assign last_step = busy_reg && (cnt_reg == LAST_STEP);
    assign step_en   = accept || (busy_reg && (!last_step || !out_valid_reg || m_tready));

    // Multiply-accumulate on the head digit.
    assign head     = clear ? '0 : dig_reg[0];
    assign carry_in = accept ? s_tdata : carry_reg;
    assign sum      = SUM_W'(carry_in) + SUM_W'(MUL_FACTOR) * SUM_W'(head);

    // Next digit line: rotate by one, the new digit enters at the top; the
    // last step folds the remaining carry into digit 0.
    always_comb begin
        for (int i = 0; i < NUM_DIGITS - 1; i++) begin
            dig_next[i] = clear ? '0 : dig_reg[i+1];
        end
        dig_next[NUM_DIGITS-1] = sum[DIGIT_W-1:0];
        if (last_step) begin
            dig_next[0] = dig_reg[1] ^ sum[SUM_W-1:DIGIT_W];
        end
        carry_next = sum[SUM_W-1:DIGIT_W];
    end

    // Step counter and output register.
    always_comb begin
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tvalid && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (accept) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(1);
        end else if (step_en) begin
            if (last_step) begin
                busy_next      = 1'b0;
                cnt_next       = '0;
                out_valid_next = 1'b1;
                out_data_next  = '0;
                for (int i = 0; i < SHOWN_DIGITS; i++) begin
                    if (i < NUM_DIGITS) begin
                        out_data_next[i*DIGIT_W +: DIGIT_W] = dig_next[i];
                    end
                end
            end else begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Digits reset to zero; carry and output data need no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                dig_reg[i] <= '0;
            end
        end else if (step_en) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                dig_reg[i] <= dig_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            carry_reg <= carry_next;
        end
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // An idle core has its step counter at zero.
    a_idle_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> cnt_reg == '0)
        else $error("step counter not cleared while idle");

    // A busy core is past its first step.
    a_busy_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != '0)
        else $error("busy with step counter at zero");

    // An accepted item starts the fold.
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> busy_reg)
        else $error("accepted item did not start the fold");

    // A new digest only appears at the end of a fold.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(last_step))
        else $error("digest appeared without a finished fold");

endmodule : multiply_carry_word_checksum_core
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiply-carry word checksum core testbench
// Sends 16-bit words, alone or in messages opened by the first flag, with
// random gaps and output stalls. Each digest is checked against a local fold
// of the same words or a typed digest. A short table of edge cases runs first.
// ----------------------------------------------------------------------------
module tb_top;
    import mcwc_pkg::*;

    localparam int DIGITS       = NUM_DIGITS_DEF;
    localparam int ITEM_TARGET  = 1400;
    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AT      = 300;
    localparam int DRAIN_CYCLES = 4 * DIGITS + 8;

    // One row of the directed table; the digest is typed in only when known.
    typedef struct {
        logic [DIGIT_W-1:0]  word;
        logic                first;
        bit                  known;
        logic [DIGEST_W-1:0] digest;
    } word_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [DIGIT_W-1:0]  s_tdata;   // [15:0] word
    logic                s_tuser;   // [0] first
    logic                m_tvalid;
    logic                m_tready;
    logic [DIGEST_W-1:0] m_tdata;   // [63:0] digest

    // Local copy of the stored digits and the digests still to come.
    logic [DIGIT_W-1:0]  digit_q [DIGITS];
    logic [DIGEST_W-1:0] digests_due [$];
    int                  mismatches;
    int                  words_sent;
    int                  quiet_cycles;

    word_row_t edge_rows [20] = '{
        '{16'h0000, 1'b0, 1'b1, 64'h0000_0000_0000_0000},
        '{16'h1234, 1'b0, 1'b1, 64'h0000_0000_0000_1234},
        '{16'hFFFF, 1'b0, 1'b0, '0},
        '{16'hFFFF, 1'b1, 1'b1, 64'h0000_0000_0000_FFFF},
        '{16'hFFFF, 1'b0, 1'b0, '0},
        '{16'hFFFF, 1'b0, 1'b0, '0},
        '{16'hFFFF, 1'b0, 1'b0, '0},
        '{16'hFFFF, 1'b0, 1'b0, '0},
        '{16'hFFFF, 1'b0, 1'b0, '0},
        '{16'hFFFF, 1'b0, 1'b0, '0},
        '{16'h0000, 1'b1, 1'b1, 64'h0000_0000_0000_0000},
        '{16'h0000, 1'b0, 1'b1, 64'h0000_0000_0000_0000},
        '{16'h8000, 1'b1, 1'b1, 64'h0000_0000_0000_8000},
        '{16'h0001, 1'b0, 1'b0, '0},
        '{16'hAAAA, 1'b0, 1'b0, '0},
        '{16'h5555, 1'b1, 1'b1, 64'h0000_0000_0000_5555},
        '{16'h5555, 1'b0, 1'b0, '0},
        '{16'hFFFF, 1'b0, 1'b0, '0},
        '{16'h0001, 1'b1, 1'b1, 64'h0000_0000_0000_0001},
        '{16'hFFFE, 1'b0, 1'b0, '0}
    };

    multiply_carry_word_checksum_core #(
        .NUM_DIGITS (DIGITS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock, 2 ns period.
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Fold one word into the local digits and return the new digest.
    function automatic logic [DIGEST_W-1:0] fold_word(input logic [DIGIT_W-1:0] word,
                                                      input logic first);
        logic [SUM_W-1:0]    carry;
        logic [DIGEST_W-1:0] digest;
        carry  = SUM_W'(word);
        digest = '0;
        if (first) begin
            for (int k = 0; k < DIGITS; k++) digit_q[k] = '0;
        end
        for (int k = 0; k < DIGITS; k++) begin
            carry      = carry + SUM_W'(MUL_FACTOR) * SUM_W'(digit_q[k]);
            digit_q[k] = carry[DIGIT_W-1:0];
            carry      = carry >> DIGIT_W;
        end
        digit_q[0] = digit_q[0] ^ carry[DIGIT_W-1:0];
        for (int k = 0; k < DIGITS && k < SHOWN_DIGITS; k++)
            digest[k*DIGIT_W +: DIGIT_W] = digit_q[k];
        return digest;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Offer one item after a random gap and log its digest once accepted.
    // Every third block of a hundred items runs with no gaps at all.
    task automatic offer_word(input logic [DIGIT_W-1:0] word, input logic first,
                              input bit known, input logic [DIGEST_W-1:0] typed);
        int                  gap;
        logic [DIGEST_W-1:0] predicted;
        gap = ((words_sent / 100) % 3 == 2) ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            s_tdata  = DIGIT_W'($urandom);
            s_tuser  = 1'($urandom);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = word;
        s_tuser  = first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = fold_word(word, first);
        digests_due.push_back(known ? typed : predicted);
        words_sent++;
    endtask

    // Words are mostly random, with the extremes mixed in.
    function automatic logic [DIGIT_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return DIGIT_W'($urandom);
        endcase
    endfunction

    // Stimulus: reset, the directed table, then random messages and noise.
    initial begin : stimulus
        int len;
        for (int k = 0; k < DIGITS; k++) digit_q[k] = '0;
        mismatches = 0;
        words_sent = 0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        foreach (edge_rows[i])
            offer_word(edge_rows[i].word, edge_rows[i].first,
                       edge_rows[i].known, edge_rows[i].digest);

        while (words_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0) begin
                // Loose word with a random first flag.
                offer_word(pick_word(), 1'($urandom), 1'b0, '0);
            end else begin
                // A message opened by the first flag.
                len = $urandom_range(1, 24);
                for (int j = 0; j < len; j++)
                    offer_word(pick_word(), j == 0, 1'b0, '0);
            end
        end
        @(negedge aclk);
        s_tvalid = 1'b0;

        // Drain, then leave room for any stray result.
        while (digests_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Receiver: random stalls, calm stretches and one long hold-off.
    initial begin : receiver
        int stall;
        int taken;
        taken    = 0;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            if (taken == HOLD_AT) begin
                @(negedge aclk);
                m_tready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
            end
            stall = ((taken / 100) % 3 == 1) ? 0 : $urandom_range(0, 5);
            repeat (stall) begin
                @(negedge aclk);
                m_tready = 1'b0;
            end
            @(negedge aclk);
            m_tready = 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            taken++;
        end
    end

    // Compare each digest with the oldest one logged.
    always @(posedge aclk) begin
        logic [DIGEST_W-1:0] wanted;
        if (aresetn && m_tvalid && m_tready) begin
            if (digests_due.size() == 0) begin
                report_mismatch($sformatf("unexpected digest %h", m_tdata));
            end else begin
                wanted = digests_due.pop_front();
                if (m_tdata !== wanted)
                    report_mismatch($sformatf("digest %h, wanted %h", m_tdata, wanted));
            end
        end
    end

    // Watchdog: too long without any item moving ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial quiet_cycles = 0;

endmodule
